### hdl/tlbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and codes of the table search block.
// No dependencies; every other file imports this package.
package tlbs_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int VALUE_W   = 32;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 4;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LIN    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIN    = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

endpackage
`default_nettype wire

### hdl/tlbs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel: operation code and value/key, valid/ready handshake.
// Depends on tlbs_pkg.
interface tlbs_in_if import tlbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

### hdl/tlbs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Response channel: status and one-based position, valid/ready handshake.
// Depends on tlbs_pkg.
interface tlbs_out_if import tlbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;

	modport source (output valid, output status, output position, input ready);
	modport sink   (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

### hdl/table_linear_binary_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Table of DEPTH signed 32-bit values in one synchronous memory
// with a fill count. Append stores at the next position (or reports full),
// linear find scans newest to oldest, binary find bisects positions
// 1..fill assuming ascending order. Every request transaction yields one
// response transaction; one request is worked on at a time. Linear find
// reads one entry per cycle with reads pipelined against the compare;
// binary find alternates a read state and a compare state for each probe.
// A result that finds the previous response still unaccepted is held
// in S_DONE until the output is free. Depends on tlbs_pkg, tlbs_in_if,
// tlbs_out_if.
module table_linear_binary_search import tlbs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	tlbs_in_if.sink       req,
	tlbs_out_if.source    rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_APPEND  = 3'd1;
	localparam logic [2:0] S_LIN     = 3'd2;
	localparam logic [2:0] S_BIN_RD  = 3'd3;
	localparam logic [2:0] S_BIN_CHK = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	typedef struct packed {
		logic                vld;
		logic [STATUS_W-1:0] status;
		logic [CW-1:0]       pos;
	} fin_t;

	logic signed [VALUE_W-1:0] mem [DEPTH];

	logic [2:0]                state_q;
	logic [CW-1:0]             fill_q;
	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [POS_W-1:0]          out_pos_q;
	logic                      chk_vld_q;
	logic [CW-1:0]             chk_pos_q;
	logic [CW-1:0]             scan_q;
	logic [CW-1:0]             low_q;
	logic [CW-1:0]             high_q;
	logic [CW-1:0]             mid_q;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [VALUE_W-1:0] rd_data_q;
	fin_t                      res_q;

	fin_t                      fin;
	logic                      full;
	logic                      out_free;
	logic                      lin_hit;
	logic [CW:0]               sum;
	logic [CW-1:0]             mid;
	logic [AW-1:0]             rd_addr;

	assign full     = (fill_q == CW'(DEPTH));
	assign out_free = !out_valid_q || rsp.ready;
	assign lin_hit  = chk_vld_q && (rd_data_q == key_q);
	assign sum      = {1'b0, low_q} + {1'b0, high_q};
	assign mid      = sum[CW:1];

	always_comb begin
		unique case (state_q)
			S_LIN:    rd_addr = AW'(scan_q - 1'b1);
			S_BIN_RD: rd_addr = AW'(mid - 1'b1);
			default:  rd_addr = '0;
		endcase
	end

	always_comb begin
		fin = '0;
		unique case (state_q)
			S_APPEND: begin
				fin.vld = 1'b1;
				if (full) begin
					fin.status = STAT_FULL;
				end else begin
					fin.status = STAT_OK;
					fin.pos    = CW'(fill_q + 1'b1);
				end
			end
			S_LIN: begin
				if (lin_hit) begin
					fin.vld    = 1'b1;
					fin.status = STAT_OK;
					fin.pos    = chk_pos_q;
				end else if (scan_q == '0) begin
					fin.vld    = 1'b1;
					fin.status = STAT_MISS;
				end
			end
			S_BIN_RD: begin
				if (low_q > high_q) begin
					fin.vld    = 1'b1;
					fin.status = STAT_MISS;
				end
			end
			S_BIN_CHK: begin
				if (rd_data_q == key_q) begin
					fin.vld    = 1'b1;
					fin.status = STAT_OK;
					fin.pos    = mid_q;
				end
			end
			S_DONE:  fin = res_q;
			default: fin = '0;
		endcase
	end

	// table memory: at most one write and one read per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_APPEND && !full) begin
			mem[fill_q[AW-1:0]] <= key_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			chk_vld_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						chk_vld_q <= 1'b0;
						case (req.mode)
							MODE_APPEND: state_q <= S_APPEND;
							MODE_LIN:    state_q <= S_LIN;
							MODE_BIN:    state_q <= S_BIN_RD;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_APPEND: begin
					if (!full) begin
						fill_q <= CW'(fill_q + 1'b1);
					end
				end
				S_LIN: begin
					if (!fin.vld) begin
						chk_vld_q <= 1'b1;
					end
				end
				S_BIN_RD: begin
					if (!fin.vld) begin
						state_q <= S_BIN_CHK;
					end
				end
				S_BIN_CHK: begin
					if (!fin.vld) begin
						state_q <= S_BIN_RD;
					end
				end
				S_DONE: begin
				end
				default: state_q <= S_IDLE;
			endcase
			if (fin.vld) begin
				if (out_free) begin
					state_q <= S_IDLE;
				end else begin
					state_q <= S_DONE;
				end
			end
			if (fin.vld && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			key_q          <= req.value;
			scan_q         <= fill_q;
			low_q          <= CW'(1);
			high_q         <= fill_q;
			res_q.vld      <= 1'b1;
			res_q.status   <= STAT_MISS;
			res_q.pos      <= '0;
		end
		if (state_q == S_LIN && !fin.vld) begin
			chk_pos_q <= scan_q;
			scan_q    <= CW'(scan_q - 1'b1);
		end
		if (state_q == S_BIN_RD && !fin.vld) begin
			mid_q <= mid;
		end
		if (state_q == S_BIN_CHK && !fin.vld) begin
			if (rd_data_q > key_q) begin
				high_q <= CW'(mid_q - 1'b1);
			end else begin
				low_q <= CW'(mid_q + 1'b1);
			end
		end
		if (fin.vld) begin
			if (out_free) begin
				out_status_q <= fin.status;
				out_pos_q    <= POS_W'(fin.pos);
			end else begin
				res_q <= fin;
			end
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.position = out_pos_q;

endmodule
`default_nettype wire

### hdl/tlbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the table search block, bound to its top level.
// Depends on tlbs_pkg and table_linear_binary_search.
module tlbs_checker import tlbs_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                req_valid,
	input wire                req_ready,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire [STATUS_W-1:0] rsp_status,
	input wire [POS_W-1:0]    rsp_position
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in flight");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != STAT_OK) |-> (rsp_position == '0))
		else $error("nonzero position on failed response");

	a_ok_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == STAT_OK) |-> (rsp_position != '0))
		else $error("zero position on successful response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
			&& $stable(rsp_position)))
		else $error("stalled response dropped or changed");

endmodule

bind table_linear_binary_search tlbs_checker u_tlbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_position (rsp.position)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for table_linear_binary_search: a directed table of requests,
// then random finds, appends and unused modes; each response is checked against a
// predictor or a typed answer. Depends on tlbs_pkg, both interfaces and the block.
module tb;
	import tlbs_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int SCRIPT_LEN = 24;
	localparam int RANDOM_LEN = 440;
	localparam int CALM_FROM = SCRIPT_LEN + 360;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} answer_t;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		logic                      typed;
		logic [STATUS_W-1:0]       status;
		logic [POS_W-1:0]          position;
	} request_t;

	logic clk = 1'b0;
	logic arst_n;

	tlbs_in_if  req_if ();
	tlbs_out_if rsp_if ();

	table_linear_binary_search #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// typed status/position apply only where the typed bit is set
	request_t script [SCRIPT_LEN] = '{
		'{MODE_LIN,    32'sd0,            1'b1, STAT_MISS, 4'd0},
		'{MODE_BIN,    32'sd0,            1'b1, STAT_MISS, 4'd0},
		'{MODE_UNUSED, -32'sd1,           1'b1, STAT_MISS, 4'd0},
		'{MODE_APPEND, 32'sh8000_0000,    1'b1, STAT_OK,   4'd1},
		'{MODE_BIN,    32'sh8000_0000,    1'b0, STAT_OK,   4'd0},
		'{MODE_APPEND, -32'sd1,           1'b1, STAT_OK,   4'd2},
		'{MODE_APPEND, -32'sd1,           1'b1, STAT_OK,   4'd3},
		'{MODE_LIN,    -32'sd1,           1'b1, STAT_OK,   4'd3},
		'{MODE_BIN,    -32'sd1,           1'b0, STAT_OK,   4'd0},
		'{MODE_APPEND, 32'sd5,            1'b1, STAT_OK,   4'd4},
		'{MODE_APPEND, 32'sd100,          1'b1, STAT_OK,   4'd5},
		'{MODE_BIN,    32'sd100,          1'b0, STAT_OK,   4'd0},
		'{MODE_BIN,    32'sd6,            1'b1, STAT_MISS, 4'd0},
		'{MODE_APPEND, 32'sh7fff_0000,    1'b1, STAT_OK,   4'd6},
		'{MODE_APPEND, 32'sh7fff_ffff,    1'b1, STAT_OK,   4'd7},
		'{MODE_BIN,    32'sh7fff_ffff,    1'b0, STAT_OK,   4'd0},
		'{MODE_LIN,    32'sd7,            1'b1, STAT_MISS, 4'd0},
		'{MODE_APPEND, 32'sd0,            1'b1, STAT_OK,   4'd8},
		'{MODE_APPEND, 32'sd42,           1'b1, STAT_FULL, 4'd0},
		'{MODE_BIN,    32'sd0,            1'b0, STAT_OK,   4'd0},
		'{MODE_LIN,    32'sd0,            1'b1, STAT_OK,   4'd8},
		'{MODE_BIN,    32'sd5,            1'b0, STAT_OK,   4'd0},
		'{MODE_LIN,    32'sh8000_0000,    1'b1, STAT_OK,   4'd1},
		'{MODE_UNUSED, 32'sh7fff_ffff,    1'b1, STAT_MISS, 4'd0}
	};

	logic signed [VALUE_W-1:0] tbl_vals [DEPTH];
	int                        tbl_fill;
	answer_t                   expected_answers [$];
	int                        failures;
	int                        n_ok;
	int                        n_full;
	int                        n_miss;
	bit                        idle_on;

	function automatic answer_t table_answer(input logic [MODE_W-1:0] mode,
			input logic signed [VALUE_W-1:0] key);
		answer_t a;
		int pos;
		int lo;
		int hi;
		int mid;
		a.status = STAT_MISS;
		a.position = '0;
		case (mode)
			MODE_APPEND: begin
				if (tbl_fill >= DEPTH) begin
					a.status = STAT_FULL;
				end else begin
					tbl_vals[tbl_fill] = key;
					tbl_fill++;
					a.status = STAT_OK;
					a.position = POS_W'(tbl_fill);
				end
			end
			MODE_LIN: begin
				pos = tbl_fill;
				while (pos > 0 && tbl_vals[pos-1] != key)
					pos--;
				if (pos > 0) begin
					a.status = STAT_OK;
					a.position = POS_W'(pos);
				end
			end
			MODE_BIN: begin
				lo = 1;
				hi = tbl_fill;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (tbl_vals[mid-1] == key) begin
						a.status = STAT_OK;
						a.position = POS_W'(mid);
						break;
					end
					if (tbl_vals[mid-1] > key)
						hi = mid - 1;
					else
						lo = mid + 1;
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	task automatic issue(input request_t r);
		answer_t a;
		req_if.valid <= 1'b1;
		req_if.mode  <= r.mode;
		req_if.value <= r.value;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		a = table_answer(r.mode, r.value);
		if (r.typed) begin
			a.status = r.status;
			a.position = r.position;
		end
		expected_answers.push_back(a);
	endtask

	// response checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected response: status %0d, position %0d",
					rsp_if.status, rsp_if.position);
				failures++;
			end else begin
				want = expected_answers.pop_front();
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					failures++;
				end
				if (rsp_if.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position,
						rsp_if.position);
					failures++;
				end
				case (want.status)
					STAT_OK:   n_ok++;
					STAT_FULL: n_full++;
					default:   n_miss++;
				endcase
			end
		end
	end

	// response back-pressure
	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		request_t r;
		int pick;
		int key_sel;
		logic signed [VALUE_W-1:0] stored;
		failures = 0;
		n_ok = 0;
		n_full = 0;
		n_miss = 0;
		tbl_fill = 0;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.mode <= MODE_APPEND;
		req_if.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN + RANDOM_LEN; i++) begin
			if (i < SCRIPT_LEN) begin
				r = script[i];
			end else begin
				idle_on = (i < CALM_FROM);
				r.typed = 1'b0;
				r.status = STAT_OK;
				r.position = '0;
				pick = $urandom_range(0, 99);
				key_sel = $urandom_range(0, 99);
				stored = (tbl_fill > 0) ? tbl_vals[$urandom_range(0, tbl_fill - 1)]
					: $urandom;
				if (pick < 8) begin
					r.mode = MODE_APPEND;
					r.value = $urandom;
				end else if (pick < 12) begin
					r.mode = MODE_UNUSED;
					r.value = $urandom;
				end else begin
					r.mode = (pick < 56) ? MODE_LIN : MODE_BIN;
					if (key_sel < 55)
						r.value = stored;
					else if (key_sel < 65)
						r.value = stored + 1;
					else if (key_sel < 75)
						r.value = stored - 1;
					else
						r.value = $urandom;
				end
			end
			if (idle_on && $urandom_range(0, 3) == 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			issue(r);
		end
		req_if.valid <= 1'b0;

		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Ran %0d requests on a table of %0d entries (sorted and unsorted finds).",
			SCRIPT_LEN + RANDOM_LEN, DEPTH);
		$display("Responses: %0d ok/found, %0d full, %0d not found.", n_ok, n_full, n_miss);
		if (failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
